FILE: rtl/cst_pkg.sv
`timescale 1ns / 1ps
package cst_pkg;
    typedef struct packed {
        logic signed [15:0] knot_x;
        logic signed [15:0] knot_y;
        logic signed [15:0] knot_z;
        logic               final_knot;
    } knot_t;

    typedef struct packed {
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] out_z;
        logic [11:0]        segment_index;
        logic               run_last;
        logic               status;
    } point_t;

    localparam logic [1:0] REG_TENSION    = 2'd0;
    localparam logic [1:0] REG_GRAIN      = 2'd1;
    localparam logic [1:0] REG_ALPHA_STEP = 2'd2;
endpackage

FILE: rtl/cardinal_spline_tessellator_core.sv
`timescale 1ns / 1ps
// channel  | direction | payload         | handshake
// s_ knot  | in        | cst_pkg::knot_t  | s_valid / s_ready
// m_ point | out       | cst_pkg::point_t | m_valid / m_ready
// cfg      | in        | index, data      | cfg_we, no wait
// a knot that closes no segment is taken straight from idle; a knot that closes a segment
// goes through accept, segment load, coefficient states for each axis, and per point
// alpha + 3 axes * 3 horner steps of multiply and add + present, then one closing step
// a final knot closes two segments, or none with an error result; all use the one shared 32x17 multiplier
// reset is synchronous active low, clears window, count, sequencer and output valid, and loads default settings
// each point waits in the output register; the sequencer stalls while it is full and not being taken
module cardinal_spline_tessellator_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  cst_pkg::knot_t   s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output cst_pkg::point_t  m_data,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [15:0]      cfg_data
);
    import cst_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SEG   = 4'd1;  // start segment: reset axis and point count, latch grain
    localparam logic [3:0] S_COEF  = 4'd2;  // build row sums for one axis
    localparam logic [3:0] S_PT    = 4'd3;  // alpha for point
    localparam logic [3:0] S_MUL   = 4'd4;  // multiply h by alpha
    localparam logic [3:0] S_ADD   = 4'd5;  // round and add next row
    localparam logic [3:0] S_OUT   = 4'd6;  // present point
    localparam logic [3:0] S_FIN   = 4'd7;  // present final knot or error

    // configuration
    logic [9:0]  tension_reg;
    logic [4:0]  grain_reg;
    logic [15:0] alpha_step_reg;

    // curve state
    logic signed [15:0] win_reg [3][3];
    logic [12:0] count_reg;

    logic [3:0]  state_reg;
    knot_t       knot_reg;
    logic        second_reg;   // working on second segment of a final knot
    logic [12:0] seg_reg;
    logic [4:0]  j_reg;
    logic [4:0]  g_reg;
    logic [15:0] alpha_reg;    // up to 0xffff
    logic [1:0]  ax_reg;
    logic [1:0]  row_reg;
    logic signed [31:0] p_reg [3][4];
    logic signed [31:0] h_reg;
    logic signed [48:0] prod_reg;
    logic signed [15:0] res_reg [3];
    point_t      out_reg;
    logic        out_valid_reg;

    // segment knots
    logic signed [15:0] ka, kb, kc, kd;
    always_comb begin
        logic [1:0] ai;
        ai = ax_reg;
        if (!second_reg) begin
            ka = (count_reg == 13'd2) ? win_reg[1][ai] : win_reg[0][ai];
            kb = win_reg[1][ai];
            kc = win_reg[2][ai];
            kd = (ai == 2'd0) ? knot_reg.knot_x :
                 (ai == 2'd1) ? knot_reg.knot_y : knot_reg.knot_z;
        end else begin
            ka = win_reg[1][ai];
            kb = win_reg[2][ai];
            kc = (ai == 2'd0) ? knot_reg.knot_x :
                 (ai == 2'd1) ? knot_reg.knot_y : knot_reg.knot_z;
            kd = kc;
        end
    end

    // row sums, small constant-like products of tension and knots
    logic signed [31:0] p0, p1, p2, p3;
    always_comb begin
        logic signed [11:0] t;
        t  = $signed({2'b00, tension_reg});
        p0 = -t * ka + (12'sd512 - t) * kb + (t - 12'sd512) * kc + t * kd;
        p1 = 12'sd2 * t * ka + (t - 12'sd768) * kb
             + (12'sd768 - 12'sd2 * t) * kc - t * kd;
        p2 = -t * ka + t * kc;
        p3 = 32'(kb) <<< 8;
    end

    // shared multiplier: h * alpha
    logic signed [48:0] mul_res;
    assign mul_res = h_reg * $signed({1'b0, alpha_reg});

    // rounding of product and final output
    logic signed [31:0] rnd;
    assign rnd = 32'((prod_reg + 49'sd32768) >>> 16);

    logic signed [31:0] sum_h;
    logic signed [23:0] coord;
    logic signed [15:0] sat;
    always_comb begin
        sum_h = p_reg[ax_reg][row_reg] + rnd;
        coord = 24'((sum_h + 32'sd128) >>> 8);
        if (coord > 24'sd32767)       sat = 16'sd32767;
        else if (coord < -24'sd32768) sat = -16'sd32768;
        else                          sat = coord[15:0];
    end

    // output register takes a new point when it is free or being emptied
    logic out_load;
    assign out_load = (!out_valid_reg || m_ready) &&
                      ((state_reg == S_OUT && j_reg < g_reg) || state_reg == S_FIN);

    logic [20:0] al_full;
    assign al_full = j_reg * alpha_step_reg;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tension_reg    <= 10'd128;
            grain_reg      <= 5'd20;
            alpha_step_reg <= 16'd3277;
            count_reg      <= '0;
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            second_reg     <= 1'b0;
            for (int a = 0; a < 3; a++)
                for (int b = 0; b < 3; b++) win_reg[a][b] <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_TENSION:    tension_reg    <= cfg_data[9:0];
                    REG_GRAIN:      grain_reg      <= cfg_data[4:0];
                    REG_ALPHA_STEP: alpha_step_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (out_load) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: if (s_valid) begin
                    knot_reg   <= s_data;
                    second_reg <= 1'b0;
                    seg_reg    <= count_reg - 13'd2;
                    if (s_data.final_knot && count_reg < 13'd2) state_reg <= S_FIN;
                    else if (count_reg >= 13'd2) state_reg <= S_SEG;
                    else begin
                        win_reg[0] <= win_reg[1];
                        win_reg[1] <= win_reg[2];
                        win_reg[2] <= '{s_data.knot_x, s_data.knot_y, s_data.knot_z};
                        count_reg  <= count_reg + 13'd1;
                    end
                end
                S_SEG: begin
                    ax_reg    <= 2'd0;
                    j_reg     <= '0;
                    g_reg     <= grain_reg;
                    state_reg <= S_COEF;
                end
                S_COEF: begin
                    p_reg[ax_reg] <= '{p0, p1, p2, p3};
                    if (ax_reg == 2'd2) begin
                        state_reg <= (g_reg == 5'd0) ? S_OUT : S_PT;
                    end else ax_reg <= ax_reg + 2'd1;
                end
                S_PT: begin
                    alpha_reg <= (al_full > 21'd65535) ? 16'hffff : al_full[15:0];
                    ax_reg    <= 2'd0;
                    row_reg   <= 2'd1;
                    h_reg     <= p_reg[0][0];
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    prod_reg  <= mul_res;
                    state_reg <= S_ADD;
                end
                S_ADD: begin
                    if (row_reg == 2'd3) begin
                        res_reg[ax_reg] <= sat;
                        if (ax_reg == 2'd2) state_reg <= S_OUT;
                        else begin
                            ax_reg    <= ax_reg + 2'd1;
                            row_reg   <= 2'd1;
                            h_reg     <= p_reg[ax_reg + 2'd1][0];
                            state_reg <= S_MUL;
                        end
                    end else begin
                        h_reg     <= sum_h;
                        row_reg   <= row_reg + 2'd1;
                        state_reg <= S_MUL;
                    end
                end
                S_OUT: if (!out_valid_reg || m_ready) begin
                    if (j_reg < g_reg) begin
                        out_reg       <= '{res_reg[0], res_reg[1], res_reg[2],
                                           seg_reg[11:0], 1'b0, 1'b0};
                        j_reg         <= j_reg + 5'd1;
                        state_reg     <= (j_reg + 5'd1 < g_reg) ? S_PT : S_OUT;
                    end else if (knot_reg.final_knot && !second_reg) begin
                        second_reg <= 1'b1;
                        seg_reg    <= count_reg - 13'd1;
                        state_reg  <= S_SEG;
                    end else if (knot_reg.final_knot) begin
                        state_reg <= S_FIN;
                    end else begin
                        win_reg[0] <= win_reg[1];
                        win_reg[1] <= win_reg[2];
                        win_reg[2] <= '{knot_reg.knot_x, knot_reg.knot_y,
                                        knot_reg.knot_z};
                        if (count_reg != 13'd8191) count_reg <= count_reg + 13'd1;
                        state_reg <= S_IDLE;
                    end
                end
                S_FIN: if (!out_valid_reg || m_ready) begin
                    if (count_reg < 13'd2)
                        out_reg <= '{16'sd0, 16'sd0, 16'sd0, 12'd0, 1'b1, 1'b1};
                    else
                        out_reg <= '{knot_reg.knot_x, knot_reg.knot_y, knot_reg.knot_z,
                                     seg_reg[11:0], 1'b1, 1'b0};
                    count_reg     <= '0;
                    for (int a = 0; a < 3; a++)
                        for (int b = 0; b < 3; b++) win_reg[a][b] <= '0;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // a new knot is only taken while the sequencer is idle
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == S_IDLE) else $error("ready outside idle");
    // error results always close a run
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status |-> m_data.run_last) else $error("error not last");
    // a held result is not overwritten
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data)) else $error("result lost");
endmodule

FILE: bench/cardinal_spline_tessellator_core_test.sv
`timescale 1ns / 1ps
module cardinal_spline_tessellator_core_test;
    import cst_pkg::*;

    // curve geometry predictor and the queue of points still owed
    class point_board;
        point_t owed[$];
        int unsigned errors;
        int unsigned checked;
        logic signed [15:0] win[3][3];
        int unsigned knots_seen;
        int unsigned tension;
        int unsigned grain;
        int unsigned alpha_step;

        function new();
            errors = 0;
            checked = 0;
            tension = 128;
            grain = 20;
            alpha_step = 3277;
            clear_curve();
        endfunction

        function void clear_curve();
            for (int i = 0; i < 3; i++)
                for (int a = 0; a < 3; a++)
                    win[i][a] = '0;
            knots_seen = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] v);
            if (idx == REG_TENSION)
                tension = v[9:0];
            else if (idx == REG_GRAIN)
                grain = v[4:0];
            else if (idx == REG_ALPHA_STEP)
                alpha_step = v;
        endfunction

        function longint scale_alpha(longint h, longint al);
            longint hi;
            longint lo;
            hi = h >>> 16;
            lo = h - (hi <<< 16);
            return hi * al + ((lo * al + 32768) >>> 16);
        endfunction

        function logic signed [15:0] round_sat(longint h);
            longint r;
            r = (h + 128) >>> 8;
            if (r > 32767) r = 32767;
            if (r < -32768) r = -32768;
            return r[15:0];
        endfunction

        function void add_point(logic signed [15:0] c[3], int unsigned seg,
                                logic last, logic st);
            point_t p;
            p.out_x = c[0];
            p.out_y = c[1];
            p.out_z = c[2];
            p.segment_index = seg[11:0];
            p.run_last = last;
            p.status = st;
            owed.push_back(p);
        endfunction

        function void tessellate(logic signed [15:0] km1[3], logic signed [15:0] k0[3],
                                 logic signed [15:0] k1[3], logic signed [15:0] k2[3],
                                 int unsigned seg);
            longint t;
            longint coef[3][4];
            longint a, b, c, d, h, al;
            logic signed [15:0] pt[3];
            int unsigned g;
            t = tension;
            g = (grain > 31) ? 31 : grain;
            for (int ax = 0; ax < 3; ax++) begin
                a = km1[ax]; b = k0[ax]; c = k1[ax]; d = k2[ax];
                coef[ax][0] = -t * a + (512 - t) * b + (t - 512) * c + t * d;
                coef[ax][1] = 2 * t * a + (t - 768) * b + (768 - 2 * t) * c - t * d;
                coef[ax][2] = -t * a + t * c;
                coef[ax][3] = 256 * b;
            end
            for (int unsigned j = 0; j < g; j++) begin
                al = longint'(j) * alpha_step;
                if (al > 65535) al = 65535;
                for (int ax = 0; ax < 3; ax++) begin
                    h = coef[ax][0];
                    h = coef[ax][1] + scale_alpha(h, al);
                    h = coef[ax][2] + scale_alpha(h, al);
                    h = coef[ax][3] + scale_alpha(h, al);
                    pt[ax] = round_sat(h);
                end
                add_point(pt, seg, 1'b0, 1'b0);
            end
        endfunction

        // note one accepted knot transfer
        function void note_knot(knot_t k);
            logic signed [15:0] kv[3];
            logic signed [15:0] zero[3];
            logic signed [15:0] prev[3];
            kv[0] = k.knot_x; kv[1] = k.knot_y; kv[2] = k.knot_z;
            zero[0] = 0; zero[1] = 0; zero[2] = 0;
            // first segment reuses its start knot as predecessor
            if (knots_seen == 2) prev = win[1];
            else prev = win[0];
            if (k.final_knot) begin
                if (knots_seen < 2) begin
                    add_point(zero, 0, 1'b1, 1'b1);
                end else begin
                    tessellate(prev, win[1], win[2], kv, knots_seen - 2);
                    tessellate(win[1], win[2], kv, kv, knots_seen - 1);
                    add_point(kv, knots_seen - 1, 1'b1, 1'b0);
                end
                clear_curve();
            end else begin
                if (knots_seen >= 2)
                    tessellate(prev, win[1], win[2], kv, knots_seen - 2);
                win[0] = win[1];
                win[1] = win[2];
                win[2] = kv;
                if (knots_seen < 8191) knots_seen++;
            end
        endfunction

        task report(string what, longint got, longint want);
            errors++;
            $display("mismatch %s: got %0d expected %0d (point %0d)", what, got, want,
                     checked);
        endtask

        task check_point(point_t p);
            point_t e;
            if (owed.size() == 0) begin
                report("unexpected point transfer", p, 0);
                return;
            end
            e = owed.pop_front();
            if (p.out_x !== e.out_x) report("out_x", p.out_x, e.out_x);
            if (p.out_y !== e.out_y) report("out_y", p.out_y, e.out_y);
            if (p.out_z !== e.out_z) report("out_z", p.out_z, e.out_z);
            if (p.segment_index !== e.segment_index)
                report("segment_index", p.segment_index, e.segment_index);
            if (p.run_last !== e.run_last) report("run_last", p.run_last, e.run_last);
            if (p.status !== e.status) report("status", p.status, e.status);
            checked++;
        endtask
    endclass

    logic    aclk;
    logic    aresetn;
    logic    s_valid;
    logic    s_ready;
    knot_t   s_data;
    logic    m_valid;
    logic    m_ready;
    point_t  m_data;
    logic    cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    point_board board;
    int unsigned knots_sent;
    int unsigned curves_sent;
    bit sink_on;

    cardinal_spline_tessellator_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 4 ns clock
    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // point sink: random backpressure, checks each transfer
    initial begin
        int unsigned hold;
        m_ready = 1'b0;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                board.check_point(m_data);
            if (!sink_on || hold == 0) begin
                m_ready <= 1'b1;
                hold = sink_on ? gap_len() : 0;
            end else begin
                m_ready <= 1'b0;
                hold--;
            end
        end
    end

    // one knot transfer, held until accepted
    task automatic send_knot(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z, logic fin);
        knot_t k;
        int unsigned g;
        k.knot_x = x;
        k.knot_y = y;
        k.knot_z = z;
        k.final_knot = fin;
        s_valid <= 1'b1;
        s_data <= k;
        do @(posedge aclk); while (!s_ready);
        board.note_knot(k);
        knots_sent++;
        if (fin) curves_sent++;
        g = gap_len();
        if (g != 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    // wait until every owed point has gone out, then let the block settle
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.owed.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        board.set_reg(idx, v);
    endtask

    task automatic set_all(logic [15:0] t, logic [15:0] g, logic [15:0] st);
        write_reg(REG_TENSION, t);
        write_reg(REG_GRAIN, g);
        write_reg(REG_ALPHA_STEP, st);
    endtask

    function automatic logic signed [15:0] rand_coord();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'sh7fff;
        if (r == 1) return 16'sh8000;
        if (r < 5) return 16'($urandom);
        return $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
    endfunction

    // random curve of n knots, last one marked final
    task automatic random_curve(int n);
        for (int i = 0; i < n; i++)
            send_knot(rand_coord(), rand_coord(), rand_coord(), i == n - 1);
    endtask

    initial begin
        board = new();
        knots_sent = 0;
        curves_sent = 0;
        sink_on = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_we = 1'b0;
        cfg_index = REG_TENSION;
        cfg_data = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset settings, a lone final knot, a two-knot curve, a four-knot curve of extreme coordinates
        send_knot(16'sd5, -16'sd5, 16'sd7, 1'b1);
        random_curve(2);
        send_knot(16'sh7fff, 16'sh8000, 16'sd0, 1'b0);
        send_knot(16'sh8000, 16'sh7fff, -16'sd1, 1'b0);
        send_knot(16'sh7fff, 16'sh8000, 16'sd1, 1'b0);
        send_knot(16'sh8000, 16'sh7fff, 16'sd0, 1'b1);
        drain();

        // extremes: top tension, tension beyond range, grain zero, largest steps
        set_all(16'd512, 16'd31, 16'd65535);
        random_curve(4);
        drain();
        set_all(16'd1023, 16'd1, 16'd1);
        send_knot(16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
        send_knot(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
        send_knot(16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
        drain();
        set_all(16'd0, 16'd0, 16'd4000);
        random_curve(3);
        random_curve(1);
        drain();
        set_all(16'd0, 16'd31, 16'd2114);
        random_curve(3);
        drain();

        // random phase with stalls on both sides
        sink_on = 1'b1;
        while (knots_sent < 95) begin
            set_all(16'($urandom_range(0, 1023)), 16'($urandom_range(1, 12)),
                    16'($urandom_range(1, 65535)));
            for (int c = 0; c < 3; c++) begin
                if ($urandom_range(0, 9) == 0)
                    random_curve($urandom_range(1, 2));
                else
                    random_curve($urandom_range(3, 8));
            end
            drain();
        end

        sink_on = 1'b0;
        drain();
        $display("covered %0d knots in %0d curves, %0d points checked", knots_sent,
                 curves_sent, board.checked);
        $display("tension, grain and step swept incl. extremes, with stalls on both sides");
        if (board.errors == 0 && board.owed.size() == 0)
            $display("PASS cardinal_spline_tessellator_core");
        else
            $display("FAIL cardinal_spline_tessellator_core");
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("FAIL cardinal_spline_tessellator_core");
        $finish;
    end
endmodule
